>>> sv/fbdc_pkg.sv
// shared types, default geometry, request codes and panel command constants for the dirty-tile frame store
`timescale 1ns / 1ps
`default_nettype none

package fbdc_pkg;

	// default geometry
	localparam int unsigned PANEL_WIDTH_DEF  = 128;
	localparam int unsigned PANEL_HEIGHT_DEF = 64;
	localparam int unsigned TILE_COLUMNS_DEF = 32;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_LINE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_FLUSH = 2'd3;

	// panel position commands
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_LO_MASK   = 8'h0F;
	localparam logic [7:0] CMD_HI_MASK   = 8'hF0;
	localparam logic [7:0] CMD_HI_BASE   = 8'h10;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] x_start;
		logic [7:0] x_end;
		logic [7:0] row;
		logic [7:0] pixel_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_command;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

>>> sv/fbdc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module fbdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/framebuffer_dirty_chunk_flush.sv
// top level: page-organised monochrome frame store with dirty tiles and tile flush
//
//  channel   ports                    handshake
//  -------   ----------------------   ------------------------------------------
//  request   start, busy, req         taken at a rising edge with start high, busy low
//  result    strobe, res              one cycle per byte, strobe high, no back-pressure
//
// behaviour, per request (defaults: 128x64 panel, 32-column tiles, 1024-byte store)
//  write : taken in the accept cycle, busy never rises
//  line  : one store read-modify-write per column, then a drain state before idle
//  clear : one store entry zeroed per cycle over the whole store
//  flush : scan one dirty mark per cycle up to the first dirty tile, then 3 command
//          bytes and TILE_COLUMNS data bytes back to back (35 strobes by default);
//          the last byte shows on res in the same cycle in which busy falls
//  the single store (one read and one write per cycle) paces all of these requests
// reset: a clearing pass zeroes the whole store with busy high, and every dirty mark
// comes up set; results cannot be stalled by the receiver
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_dirty_chunk_flush #(
	parameter int unsigned PANEL_WIDTH  = fbdc_pkg::PANEL_WIDTH_DEF,
	parameter int unsigned PANEL_HEIGHT = fbdc_pkg::PANEL_HEIGHT_DEF,
	parameter int unsigned TILE_COLUMNS = fbdc_pkg::TILE_COLUMNS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire fbdc_pkg::req_t  req,
	output logic                 strobe,
	output fbdc_pkg::res_t       res
);

	// geometry
	localparam int unsigned NUM_PAGES  = PANEL_HEIGHT / 8;
	localparam int unsigned TPP        = PANEL_WIDTH / TILE_COLUMNS;
	localparam int unsigned NUM_TILES  = TPP * NUM_PAGES;
	localparam int unsigned STORE_SIZE = PANEL_WIDTH * NUM_PAGES;
	localparam int unsigned AW         = $clog2(STORE_SIZE);
	localparam int unsigned EAW        = AW + 1;
	localparam int unsigned NT1        = (NUM_TILES > 0) ? NUM_TILES : 1;
	localparam int unsigned DW         = (NT1 > 1) ? $clog2(NT1) : 1;
	localparam int unsigned SCW        = DW + 1;
	localparam int unsigned PW         = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int unsigned CW         = $clog2(TILE_COLUMNS);
	localparam int unsigned COLT_MAX   = 255 / TILE_COLUMNS;
	localparam int unsigned CTW        = (COLT_MAX > 1) ? $clog2(COLT_MAX + 1) : 1;
	localparam int unsigned TSUM_W     = $clog2(NUM_PAGES * TPP + COLT_MAX + 1);
	localparam logic [NT1-1:0] DIRTY_ALL = (NUM_TILES > 0) ? '1 : '0;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_LINE   = 4'd2;
	localparam logic [3:0] S_LDRAIN = 4'd3;
	localparam logic [3:0] S_SCAN   = 4'd4;
	localparam logic [3:0] S_CMD0   = 4'd5;
	localparam logic [3:0] S_CMD1   = 4'd6;
	localparam logic [3:0] S_CMD2   = 4'd7;
	localparam logic [3:0] S_DATA   = 4'd8;

	logic [3:0]      state_q;
	logic [AW-1:0]   cnt_q;      // clearing sweep address
	logic [7:0]      x_q;        // line column
	logic [7:0]      xe_q;       // clamped last column of line
	logic [7:0]      mask_q;     // line pixel bit
	logic [PW-1:0]   page_q;
	logic [EAW-1:0]  rb_q;       // page base address in the store
	logic [7:0]      col_q;      // first column of scanned tile
	logic [SCW-1:0]  idx_q;      // scanned tile index
	logic [CW-1:0]   c_q;        // data byte counter
	logic [NT1-1:0]  dirty_q;

	// read-modify-write pipeline of the line walk
	logic            wr_pend_s1;
	logic [AW-1:0]   wr_addr_s1;
	logic            last_s1;

	logic            strobe_q;
	fbdc_pkg::res_t  res_q;

	// ram ports
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;

	// column to tile-in-page table
	logic [CTW-1:0]  col_tile [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_col_tile
		assign col_tile[gi] = CTW'(gi / TILE_COLUMNS);
	end

	// request decode
	logic            acc;
	logic            w_ok;
	logic            l_ok;
	logic [AW-1:0]   w_addr;
	logic [7:0]      xe_cl;
	logic [PW-1:0]   l_page;

	assign acc  = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	assign w_ok = ({1'b0, req.x_start} < 9'(PANEL_WIDTH)) && (req.row < 8'(NUM_PAGES));
	assign l_ok = (req.row < 8'(PANEL_HEIGHT))
		&& ({1'b0, req.x_start} < 9'(PANEL_WIDTH))
		&& (req.x_start <= req.x_end);
	assign w_addr = AW'(req.row) * AW'(PANEL_WIDTH) + AW'(req.x_start);
	assign xe_cl  = ({1'b0, req.x_end} >= 9'(PANEL_WIDTH)) ? 8'(PANEL_WIDTH - 1) : req.x_end;
	assign l_page = req.row[PW+2:3];

	// tile marking, shared by write and line walk
	logic [7:0]        mk_x;
	logic [PW-1:0]     mk_page;
	logic [TSUM_W-1:0] mk_t;
	logic              mk_en;

	always_comb begin
		if (state_q == S_LINE) begin
			mk_x    = x_q;
			mk_page = page_q;
		end else begin
			mk_x    = req.x_start;
			mk_page = req.row[PW-1:0];
		end
	end

	assign mk_t  = TSUM_W'(mk_page) * TSUM_W'(TPP) + TSUM_W'(col_tile[mk_x]);
	assign mk_en = ((state_q == S_LINE) || (acc && (req.req_type == fbdc_pkg::REQ_WRITE) && w_ok))
		&& ({1'b0, mk_t} < (TSUM_W + 1)'(NUM_TILES));

	// flush address generation
	logic [EAW-1:0] da;
	logic           tile_dirty;
	logic           scan_end;
	logic           page_wrap;

	assign da         = rb_q + EAW'(col_q) + EAW'(c_q);
	assign tile_dirty = dirty_q[idx_q[DW-1:0]];
	assign scan_end   = (idx_q == SCW'(NUM_TILES));
	assign page_wrap  = ({2'b00, col_q} + 10'(2 * TILE_COLUMNS)) > 10'(PANEL_WIDTH);

	// store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = 8'h00;
		if (wr_pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = ram_rdata | mask_q;
		end else if (state_q == S_CLR) begin
			ram_we = 1'b1;
		end else if (acc && (req.req_type == fbdc_pkg::REQ_WRITE) && w_ok) begin
			ram_we    = 1'b1;
			ram_waddr = w_addr;
			ram_wdata = req.pixel_byte;
		end
	end

	assign ram_raddr = (state_q == S_LINE) ? AW'(rb_q + EAW'(x_q)) : AW'(da);

	fbdc_ram #(
		.WIDTH (8),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			cnt_q      <= '0;
			wr_pend_s1 <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == S_LINE);
			strobe_q   <= (state_q == S_CMD0) || (state_q == S_CMD1)
				|| (state_q == S_CMD2) || (state_q == S_DATA);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (req.req_type)
							fbdc_pkg::REQ_WRITE: state_q <= S_IDLE;
							fbdc_pkg::REQ_LINE:  state_q <= l_ok ? S_LINE : S_IDLE;
							fbdc_pkg::REQ_CLEAR: begin
								state_q <= S_CLR;
								cnt_q   <= '0;
							end
							fbdc_pkg::REQ_FLUSH: state_q <= S_SCAN;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_CLR: begin
					if (cnt_q == AW'(STORE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_LINE: begin
					if (x_q == xe_q) begin
						state_q <= S_LDRAIN;
					end
				end
				S_LDRAIN: state_q <= S_IDLE;
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_IDLE;
					end else if (tile_dirty) begin
						state_q <= S_CMD0;
					end
				end
				S_CMD0: state_q <= S_CMD1;
				S_CMD1: state_q <= S_CMD2;
				S_CMD2: state_q <= S_DATA;
				S_DATA: begin
					if (last_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		// line and flush setup, line walk, flush scan and byte count
		if (acc && (req.req_type == fbdc_pkg::REQ_LINE)) begin
			x_q    <= req.x_start;
			xe_q   <= xe_cl;
			mask_q <= 8'b1 << req.row[2:0];
			page_q <= l_page;
			rb_q   <= EAW'(l_page) * EAW'(PANEL_WIDTH);
		end else if (acc && (req.req_type == fbdc_pkg::REQ_FLUSH)) begin
			idx_q  <= '0;
			page_q <= '0;
			col_q  <= '0;
			rb_q   <= '0;
			c_q    <= '0;
		end else if (state_q == S_LINE) begin
			x_q <= x_q + 8'd1;
		end else if ((state_q == S_SCAN) && !scan_end && !tile_dirty) begin
			idx_q <= idx_q + 1'b1;
			if (page_wrap) begin
				col_q  <= '0;
				page_q <= page_q + 1'b1;
				rb_q   <= rb_q + EAW'(PANEL_WIDTH);
			end else begin
				col_q <= col_q + 8'(TILE_COLUMNS);
			end
		end else if ((state_q == S_CMD2) || (state_q == S_DATA)) begin
			c_q <= c_q + 1'b1;
		end

		wr_addr_s1 <= AW'(rb_q + EAW'(x_q));
		last_s1    <= (c_q == CW'(TILE_COLUMNS - 1));

		// result register
		unique case (state_q)
			S_CMD0: res_q <= '{out_byte: fbdc_pkg::CMD_PAGE_BASE + 8'(page_q),
				is_command: 1'b1, last: 1'b0};
			S_CMD1: res_q <= '{out_byte: col_q & fbdc_pkg::CMD_LO_MASK,
				is_command: 1'b1, last: 1'b0};
			S_CMD2: res_q <= '{out_byte: ((col_q & fbdc_pkg::CMD_HI_MASK) >> 4)
				| fbdc_pkg::CMD_HI_BASE, is_command: 1'b1, last: 1'b0};
			S_DATA: res_q <= '{out_byte: ram_rdata, is_command: 1'b0, last: last_s1};
			default: res_q <= res_q;
		endcase
	end

	// dirty marks: reset and clear set all, write and line set, flush clears one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= DIRTY_ALL;
		end else if (acc && (req.req_type == fbdc_pkg::REQ_CLEAR)) begin
			dirty_q <= DIRTY_ALL;
		end else begin
			if (mk_en) begin
				dirty_q[mk_t[DW-1:0]] <= 1'b1;
			end
			if ((state_q == S_SCAN) && !scan_end && tile_dirty) begin
				dirty_q[idx_q[DW-1:0]] <= 1'b0;
			end
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

endmodule

`default_nettype wire

>>> sv/fbdc_checker.sv
// port-level checks of the result stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module fbdc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           busy,
	input wire logic           strobe,
	input wire fbdc_pkg::res_t res
);

	// results only come out of a request in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a request in progress");

	// a burst opens with a page command
	a_burst_head: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !$past(strobe)) |-> (res.is_command
			&& ((res.out_byte & fbdc_pkg::CMD_HI_MASK) == fbdc_pkg::CMD_PAGE_BASE)))
		else $error("burst does not open with a page command");

	// last marks a data byte
	a_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.last) |-> !res.is_command)
		else $error("last set on a command byte");

	// a burst ends after its last byte
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.last) |=> !strobe)
		else $error("result straight after the last byte");

endmodule

bind framebuffer_dirty_chunk_flush fbdc_checker u_fbdc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.strobe (strobe),
	.res    (res)
);

`default_nettype wire

>>> tb/fbdc_flush_checker.sv
// checker: predicts panel bytes from accepted requests and compares each strobed result
`timescale 1ns / 1ps

module fbdc_flush_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy,
	input  wire fbdc_pkg::req_t req,
	input  wire logic           strobe,
	input  wire fbdc_pkg::res_t res,
	output int unsigned         mismatch_count,
	output int unsigned         outstanding
);

	import fbdc_pkg::*;

	localparam int unsigned COLS        = PANEL_WIDTH_DEF;
	localparam int unsigned ROWS        = PANEL_HEIGHT_DEF;
	localparam int unsigned TILE_W      = TILE_COLUMNS_DEF;
	localparam int unsigned PAGES       = ROWS / 8;
	localparam int unsigned TILES_PAGE  = COLS / TILE_W;
	localparam int unsigned TILES       = TILES_PAGE * PAGES;
	localparam int unsigned STORE_BYTES = COLS * PAGES;

	logic [7:0]  page_bytes [STORE_BYTES];
	logic        tile_dirty [TILES];
	res_t        panel_bytes_q [$];
	int unsigned err_total;

	function automatic void wipe_frame();
		foreach (page_bytes[i]) page_bytes[i] = 8'h00;
		foreach (tile_dirty[i]) tile_dirty[i] = 1'b1;
	endfunction

	// updates the frame image and queues the bytes a flush sends
	function automatic void predict_request(input req_t r);
		int unsigned x;
		int unsigned x_last;
		int unsigned page;
		int unsigned t;
		int unsigned c;
		int unsigned base;
		logic [7:0]  mask;
		logic [7:0]  col8;
		bit          found;
		found = 1'b0;
		case (r.req_type)
			REQ_WRITE: begin
				if (r.x_start < COLS && r.row < PAGES) begin
					page_bytes[r.row * COLS + r.x_start] = r.pixel_byte;
					tile_dirty[r.row * TILES_PAGE + r.x_start / TILE_W] = 1'b1;
				end
			end
			REQ_LINE: begin
				if (r.row < ROWS && r.x_start < COLS && r.x_start <= r.x_end) begin
					x_last = (r.x_end >= COLS) ? COLS - 1 : r.x_end;
					page = r.row / 8;
					mask = 8'h01 << (r.row % 8);
					for (x = r.x_start; x <= x_last; x++) begin
						page_bytes[page * COLS + x] = page_bytes[page * COLS + x] | mask;
						tile_dirty[page * TILES_PAGE + x / TILE_W] = 1'b1;
					end
				end
			end
			REQ_CLEAR: begin
				wipe_frame();
			end
			default: begin
				for (t = 0; t < TILES; t++) begin
					if (!found && tile_dirty[t]) begin
						found = 1'b1;
						tile_dirty[t] = 1'b0;
						page = t / TILES_PAGE;
						col8 = 8'((t % TILES_PAGE) * TILE_W);
						base = page * COLS + col8;
						panel_bytes_q.push_back(res_t'{8'(CMD_PAGE_BASE + page), 1'b1, 1'b0});
						panel_bytes_q.push_back(res_t'{col8 & CMD_LO_MASK, 1'b1, 1'b0});
						panel_bytes_q.push_back(res_t'{((col8 & CMD_HI_MASK) >> 4) | CMD_HI_BASE,
							1'b1, 1'b0});
						for (c = 0; c < TILE_W; c++) begin
							panel_bytes_q.push_back(res_t'{
								(base + c < STORE_BYTES) ? page_bytes[base + c] : 8'h00,
								1'b0, (c + 1 == TILE_W) ? 1'b1 : 1'b0});
						end
					end
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			wipe_frame();
			panel_bytes_q.delete();
			err_total = 0;
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			// compare before predicting, a new flush only appends behind older bytes
			if (strobe) begin
				if (panel_bytes_q.size() == 0) begin
					if (err_total < 10)
						$display("unexpected byte %02h cmd %0d last %0d", res.out_byte,
							res.is_command, res.last);
					err_total++;
				end else begin
					want = panel_bytes_q.pop_front();
					if (res.out_byte !== want.out_byte || res.is_command !== want.is_command
							|| res.last !== want.last) begin
						if (err_total < 10)
							$display("mismatch: expected byte %02h cmd %0d last %0d, got %02h cmd %0d last %0d",
								want.out_byte, want.is_command, want.last,
								res.out_byte, res.is_command, res.last);
						err_total++;
					end
				end
			end
			if (start && !busy)
				predict_request(req);
			mismatch_count <= err_total;
			outstanding <= panel_bytes_q.size();
		end
	end

endmodule

>>> tb/framebuffer_dirty_chunk_flush_tb.sv
// testbench top: drives requests into the dirty-tile frame store and reports the verdict
`timescale 1ns / 1ps

module framebuffer_dirty_chunk_flush_tb;

	import fbdc_pkg::*;

	// the limit covers the slowest legal run (every request a clear) several times over
	localparam int unsigned CYCLE_LIMIT  = 1_500_000;
	localparam int unsigned RANDOM_COUNT = 310;
	// a clear keeps the block busy for a whole store pass
	localparam int unsigned TAIL_CYCLES  = 1100;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	req_t        req    = '0;
	logic        busy;
	logic        strobe;
	res_t        res;
	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned n;
	bit          calm;
	req_t        r;

	always #5 clk = ~clk;

	framebuffer_dirty_chunk_flush u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.res    (res)
	);

	fbdc_flush_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req            (req),
		.strobe         (strobe),
		.res            (res),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// watchdog, also covers the clearing pass after reset
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("framebuffer_dirty_chunk_flush_tb failed");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] xs,
			input logic [7:0] xe, input logic [7:0] row, input logic [7:0] pix);
		req_t q;
		q.req_type   = kind;
		q.x_start    = xs;
		q.x_end      = xe;
		q.row        = row;
		q.pixel_byte = pix;
		return q;
	endfunction

	// mostly well-formed requests of all four kinds, the odd drawing request out of range
	function automatic req_t random_request();
		req_t        q;
		int unsigned pick;
		q.x_start    = 8'($urandom);
		q.x_end      = 8'($urandom);
		q.row        = 8'($urandom);
		q.pixel_byte = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 40) begin
			q.req_type = REQ_WRITE;
			if ($urandom_range(9) != 0) q.x_start = 8'($urandom_range(127));
			if ($urandom_range(9) != 0) q.row = 8'($urandom_range(7));
		end else if (pick < 70) begin
			q.req_type = REQ_LINE;
			if ($urandom_range(9) != 0) begin
				q.row     = 8'($urandom_range(63));
				q.x_start = 8'($urandom_range(127));
				// short spans keep the line walk quick, a few run past the edge
				if ($urandom_range(7) != 0)
					q.x_end = 8'(q.x_start + $urandom_range(40));
				else
					q.x_end = 8'($urandom_range(255, q.x_start));
			end
		end else if (pick < 73) begin
			q.req_type = REQ_CLEAR;
		end else begin
			q.req_type = REQ_FLUSH;
		end
		return q;
	endfunction

	// hold the request on the port until the block takes it
	task automatic send_request(input req_t q);
		start <= 1'b1;
		req   <= q;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_for(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every predicted byte has come out and the block is idle
	task automatic wait_for_drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and each ignore rule
		send_request(make_req(REQ_WRITE, 8'd0,   8'd0,   8'd0,   8'hFF));
		send_request(make_req(REQ_WRITE, 8'd127, 8'd255, 8'd7,   8'hA5));
		// column or page out of range is ignored
		send_request(make_req(REQ_WRITE, 8'd128, 8'd0,   8'd0,   8'h5A));
		send_request(make_req(REQ_WRITE, 8'd255, 8'd255, 8'd255, 8'hFF));
		send_request(make_req(REQ_WRITE, 8'd5,   8'd0,   8'd8,   8'h3C));
		// end past the edge gets clamped
		send_request(make_req(REQ_LINE,  8'd0,   8'd255, 8'd0,   8'h00));
		send_request(make_req(REQ_LINE,  8'd127, 8'd127, 8'd63,  8'hFF));
		// pixel row out of range
		send_request(make_req(REQ_LINE,  8'd0,   8'd10,  8'd64,  8'h00));
		send_request(make_req(REQ_LINE,  8'd0,   8'd127, 8'd255, 8'hFF));
		// start after end, start beyond the panel
		send_request(make_req(REQ_LINE,  8'd10,  8'd9,   8'd20,  8'h00));
		send_request(make_req(REQ_LINE,  8'd128, 8'd200, 8'd5,   8'h00));
		send_request(make_req(REQ_LINE,  8'd255, 8'd255, 8'd5,   8'h00));
		// span across a tile boundary
		send_request(make_req(REQ_LINE,  8'd31,  8'd32,  8'd37,  8'h00));
		send_request(make_req(REQ_FLUSH, 8'd0,   8'd0,   8'd0,   8'h00));
		send_request(make_req(REQ_FLUSH, 8'hFF,  8'hFF,  8'hFF,  8'hFF));
		send_request(make_req(REQ_CLEAR, 8'hFF,  8'hFF,  8'hFF,  8'hFF));
		send_request(make_req(REQ_WRITE, 8'd64,  8'd0,   8'd3,   8'h00));
		send_request(make_req(REQ_LINE,  8'd96,  8'd127, 8'd56,  8'h00));
		send_request(make_req(REQ_FLUSH, 8'd0,   8'd0,   8'd0,   8'h00));
		send_request(make_req(REQ_FLUSH, 8'd0,   8'd0,   8'd0,   8'h00));
		send_request(make_req(REQ_FLUSH, 8'd0,   8'd0,   8'd0,   8'h00));
		wait_for_drain();

		// random: two bursts of 34 flushes drain every tile, so flush with
		// nothing dirty comes up; a long stretch runs with no idling
		for (n = 0; n < RANDOM_COUNT; n++) begin
			calm = (n >= 120 && n < 190);
			if (n == 60 || n == 250)
				wait_for_drain();
			else if (!calm && $urandom_range(99) < 21)
				idle_for($urandom_range(1, 12));
			if ((n >= 20 && n < 54) || (n >= 270 && n < 304)) begin
				r = random_request();
				r.req_type = REQ_FLUSH;
			end else begin
				r = random_request();
			end
			send_request(r);
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("framebuffer_dirty_chunk_flush_tb passed");
		else
			$display("framebuffer_dirty_chunk_flush_tb failed");
		$finish;
	end

endmodule

>>> sim.f
sv/fbdc_pkg.sv
sv/fbdc_ram.sv
sv/framebuffer_dirty_chunk_flush.sv
sv/fbdc_checker.sv
tb/fbdc_flush_checker.sv
tb/framebuffer_dirty_chunk_flush_tb.sv
